>>> hdl/klih_pkg.sv
`timescale 1ns / 1ps

package klih_pkg;

  localparam int unsigned HASH_W = 64;
  localparam int unsigned IDX_W  = 32;
  localparam int unsigned HALF_W = HASH_W / 2;

  // FNV-1a 64
  localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
  // prime = 2^40 + 0x1b3, so the multiply is a shift plus a narrow product
  localparam int unsigned       FNV_PRIME_SHIFT = 40;
  localparam logic [8:0]        FNV_PRIME_LO    = 9'h1b3;

  // 64-bit mixing finalizer
  localparam logic [HASH_W-1:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
  localparam logic [HASH_W-1:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned       MIX_SHIFT = 33;

  localparam logic [IDX_W-1:0]  NUM_LOCKS_RESET = 32'd1;
  localparam int unsigned       QUEUE_DEPTH     = 2;

  typedef enum logic [1:0] {
    ACT_BYTE  = 2'd0,
    ACT_ID    = 2'd1,
    ACT_EMPTY = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL0,
    F_MUL1,
    F_MUL2,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_e;

  // one finished hash moving through the queue
  typedef struct packed {
    logic              vld;
    logic [HASH_W-1:0] hash;
  } hash_beat_t;

endpackage

>>> hdl/klih_front.sv
`timescale 1ns / 1ps

module klih_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           action_i,
  input  logic [7:0]           key_byte_i,
  input  logic                 key_last_i,
  input  logic [63:0]          data_id_i,
  output klih_pkg::hash_beat_t push_o,
  input  logic                 q_full_i
);
  import klih_pkg::*;

  front_state_e      state_q, state_d;
  logic [HASH_W-1:0] hash_q, hash_d;
  logic [HASH_W-1:0] acc_q, acc_d;
  logic [HASH_W-1:0] prod_q, prod_d;
  logic              pass_q, pass_d;

  logic              in_acc;
  logic [HASH_W-1:0] hx, fnv_next, mix_k, mix_sum, id_pre;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [HASH_W-1:0] mul_p;

  assign in_stall_o = (state_q != F_IDLE) || q_full_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  // FNV-1a step: xor byte, multiply by 2^40 + 0x1b3
  assign hx       = hash_q ^ {{(HASH_W-8){1'b0}}, key_byte_i};
  assign fnv_next = (hx << FNV_PRIME_SHIFT) + (hx * {{(HASH_W-9){1'b0}}, FNV_PRIME_LO});
  assign id_pre   = data_id_i ^ (data_id_i >> MIX_SHIFT);

  // 64x64 low-half product as three 32x32 partial products, one per cycle
  assign mix_k = pass_q ? MIX_MUL_B : MIX_MUL_A;
  always_comb begin
    case (state_q)
      F_MUL1: begin
        mul_a = acc_q[HALF_W-1:0];
        mul_b = mix_k[HASH_W-1:HALF_W];
      end
      F_MUL2: begin
        mul_a = acc_q[HASH_W-1:HALF_W];
        mul_b = mix_k[HALF_W-1:0];
      end
      default: begin
        mul_a = acc_q[HALF_W-1:0];
        mul_b = mix_k[HALF_W-1:0];
      end
    endcase
  end
  assign mul_p   = mul_a * mul_b;
  assign mix_sum = prod_q + {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (in_acc && action_e'(action_i) == ACT_ID) begin
          state_d = F_MUL0;
        end
      end
      F_MUL0: state_d = F_MUL1;
      F_MUL1: state_d = F_MUL2;
      F_MUL2: state_d = pass_q ? F_PUSH : F_MUL0;
      F_PUSH: begin
        if (!q_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  // datapath and queue write
  always_comb begin
    hash_d      = hash_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    pass_d      = pass_q;
    push_o.vld  = 1'b0;
    push_o.hash = acc_q;
    case (state_q)
      F_IDLE: begin
        if (in_acc) begin
          case (action_e'(action_i))
            ACT_BYTE: begin
              if (key_last_i) begin
                push_o.vld  = 1'b1;
                push_o.hash = fnv_next;
                hash_d      = FNV_BASIS;
              end else begin
                hash_d = fnv_next;
              end
            end
            ACT_ID: begin
              acc_d  = id_pre;
              pass_d = 1'b0;
              hash_d = FNV_BASIS;
            end
            ACT_EMPTY: begin
              push_o.vld  = 1'b1;
              push_o.hash = FNV_BASIS;
              hash_d      = FNV_BASIS;
            end
            default: ;  // unused code: dropped, hash kept
          endcase
        end
      end
      F_MUL0: prod_d = mul_p;
      F_MUL1: prod_d = mix_sum;
      F_MUL2: begin
        acc_d  = mix_sum ^ (mix_sum >> MIX_SHIFT);
        pass_d = 1'b1;
      end
      F_PUSH: push_o.vld = !q_full_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      hash_q  <= FNV_BASIS;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      hash_q  <= hash_d;
      pass_q  <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    prod_q <= prod_d;
  end

endmodule

>>> hdl/klih_fifo.sv
`timescale 1ns / 1ps

module klih_fifo #(
  parameter int unsigned Depth = klih_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  klih_pkg::hash_beat_t push_i,
  output logic                 full_o,
  output klih_pkg::hash_beat_t head_o,
  input  logic                 pop_i
);
  import klih_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [HASH_W-1:0] mem [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o      = (cnt_q == CntW'(Depth));
  assign head_o.vld  = (cnt_q != '0);
  assign head_o.hash = mem[rd_q];
  assign do_push     = push_i.vld && !full_o;
  assign do_pop      = pop_i && head_o.vld;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= push_i.hash;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.vld |-> !full_o)
    else $error("hash pushed into full queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count out of range");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count did not track push");
`endif

endmodule

>>> hdl/klih_mod.sv
`timescale 1ns / 1ps

module klih_mod (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [31:0]          cfg_data_i,
  input  klih_pkg::hash_beat_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [31:0]          lock_index_o
);
  import klih_pkg::*;

  localparam int unsigned CntW = $clog2(HASH_W);

  back_state_e       state_q, state_d;
  logic [IDX_W-1:0]  num_locks_q;
  logic [IDX_W-1:0]  div_q, div_d;
  logic [IDX_W-1:0]  rem_q, rem_d;
  logic [HASH_W-1:0] dvd_q, dvd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [IDX_W-1:0]  idx_q, idx_d;

  logic              last_step, out_free;
  logic [IDX_W:0]    r_sh, r_sub;

  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign lock_index_o = idx_q;

  assign last_step = (cnt_q == CntW'(HASH_W - 1));
  assign out_free  = !out_valid_q || !out_stall_i;

  // restoring radix-2 step; remainder stays below the divisor
  assign r_sh  = {rem_q, dvd_q[HASH_W-1]};
  assign r_sub = r_sh - {1'b0, div_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (head_i.vld) begin
          state_d = B_DIV;
        end
      end
      B_DIV: begin
        if (last_step) begin
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    pop_o       = 1'b0;
    div_d       = div_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      B_IDLE: begin
        if (head_i.vld) begin
          pop_o = 1'b1;
          dvd_d = head_i.hash;
          rem_d = '0;
          cnt_d = '0;
          // zero count behaves as one lock
          div_d = (num_locks_q == '0) ? IDX_W'(1) : num_locks_q;
        end
      end
      B_DIV: begin
        rem_d = (r_sh >= {1'b0, div_q}) ? r_sub[IDX_W-1:0] : r_sh[IDX_W-1:0];
        dvd_d = {dvd_q[HASH_W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
      end
      B_DONE: begin
        if (out_free) begin
          idx_d       = rem_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      num_locks_q <= NUM_LOCKS_RESET;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        num_locks_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    idx_q <= idx_d;
  end

`ifndef ASSERT_OFF
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DIV) |-> (div_q != '0))
    else $error("divide running with zero divisor");
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_IDLE && pop_o) |=> (state_q == B_DIV && cnt_q == '0))
    else $error("divide did not start cleanly");
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == B_DONE))
    else $error("result shown without finished divide");
`endif

endmodule

>>> hdl/key_to_lock_index_hash.sv
`timescale 1ns / 1ps

// Key to lock index hash.
// Input channel (in_valid_i / in_stall_o): a beat is taken when valid is high
// and stall is low. action_i selects a key byte (FNV-1a 64, key_last_i ends the
// key), a whole 64-bit id (mixing finalizer) or an empty key (offset basis).
// Only finished keys give a result; action code 3 is dropped.
// Output channel (out_valid_o / out_stall_i): lock_index_o is the hash modulo
// the configured lock count (a count of 0 acts as 1).
// Config channel (cfg_valid_i / cfg_ready_o): writes the lock count; ready is
// always high. Write it only while no key is in flight.
// An id takes longer than a final byte or an empty key: the front runs two
// multiplies of three 32x32 partial products each, then the queue push, and
// stalls meanwhile. The result rate is set by the radix-2 modulo unit, which
// retires one dividend bit per cycle and takes a new hash only after handing
// the last result to the output. Non-final key bytes are taken one per cycle
// while the front is idle and the queue is not full.
// Front and divider are parted by a small hash queue, so bytes keep flowing
// while a result is still being reduced. When out_stall_i is high the result
// holds, the divider waits, the queue fills and then in_stall_o rises.
// Reset clears the running hash to the offset basis and the lock count to 1.
module key_to_lock_index_hash #(
  parameter int unsigned QueueDepth = klih_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  key_byte_i,
  input  logic        key_last_i,
  input  logic [63:0] data_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] lock_index_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);
  import klih_pkg::*;

  hash_beat_t push, head;
  logic       q_full, pop;

  klih_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .key_byte_i (key_byte_i),
    .key_last_i (key_last_i),
    .data_id_i  (data_id_i),
    .push_o     (push),
    .q_full_i   (q_full)
  );

  klih_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  klih_mod u_mod (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .lock_index_o (lock_index_o)
  );

endmodule
